// ===== hw/rtl/qltu_pkg.sv =====
// qltu_pkg: constants, register indexes and sequencer states of the q-learning table update core
// no dependencies
`default_nettype none
package qltu_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_STATES  = 64;
    localparam int MAX_ACTIONS = 8;
    localparam int STATE_BITS  = 6;
    localparam int ACTION_BITS = 3;
    localparam int ADDR_BITS   = STATE_BITS + ACTION_BITS;
    localparam int DEPTH       = MAX_STATES * MAX_ACTIONS;
    localparam int RATE_BITS   = 17;
    localparam int FIX_ONE     = 65536;

    localparam logic [2:0] REG_LEARN_RATE   = 3'd0;
    localparam logic [2:0] REG_DISCOUNT     = 3'd1;
    localparam logic [2:0] REG_TRACE_DECAY  = 3'd2;
    localparam logic [2:0] REG_IMPOSSIBLE   = 3'd3;
    localparam logic [2:0] REG_STATES_USE   = 3'd4;
    localparam logic [2:0] REG_ACTIONS_USE  = 3'd5;

    localparam logic [1:0] PHASE_START  = 2'd0;
    localparam logic [1:0] PHASE_FIRST  = 2'd1;
    localparam logic [1:0] PHASE_STEADY = 2'd2;

    typedef enum logic [21:0] {
        S_CLEAR  = 22'h000001,
        S_IDLE   = 22'h000002,
        S_MAXRD  = 22'h000004,
        S_MAXCMP = 22'h000008,
        S_QRD    = 22'h000010,
        S_GMUL   = 22'h000020,
        S_GWAIT  = 22'h000040,
        S_SUM    = 22'h000080,
        S_DELTA  = 22'h000100,
        S_AMUL   = 22'h000200,
        S_AWAIT  = 22'h000400,
        S_UPD    = 22'h000800,
        S_STEP   = 22'h001000,
        S_KWAIT  = 22'h002000,
        S_KEEP   = 22'h004000,
        S_SWRD   = 22'h008000,
        S_SWMUL  = 22'h010000,
        S_SWW1   = 22'h020000,
        S_SWQ    = 22'h040000,
        S_SWW2   = 22'h080000,
        S_SWT    = 22'h100000,
        S_FINISH = 22'h200000
    } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/qltu_ram.sv =====
// qltu_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none
module qltu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/q_learning_table_update_core.sv =====
// q_learning_table_update_core: q-learning / watkins q(lambda) table update engine
// depends on qltu_pkg and qltu_ram
`default_nettype none
// One item is one decision-episode observation; one result item follows each. After reset a
// clearing pass zeroes both tables before the first item is taken. Items that perform no
// update go straight to the result. A one-step update first runs the max search, which
// reads the q entries of the na actions in use one at a time. A trace update adds a sweep
// over every entry in use, paced by the single shared 32x32 multiplier and the one read port
// of each table; a greedy action adds a multiply per entry that decays its trace. The block
// takes no new item while an item is at work; the result sits in an output register.
module q_learning_table_update_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [5:0]  observed_state,
    input  wire logic [2:0]  observed_action,
    input  wire logic [31:0] observed_reward,
    input  wire logic        impossible_flag,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             update_done,
    output logic [2:0]       greedy_action,
    output logic [31:0]      greedy_value,
    output logic [31:0]      td_error,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int VB = qltu_pkg::VALUE_BITS;
    localparam int AB = qltu_pkg::ADDR_BITS;
    localparam int SB = qltu_pkg::STATE_BITS;
    localparam int CB = qltu_pkg::ACTION_BITS;
    localparam int RB = qltu_pkg::RATE_BITS;
    localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

    function automatic logic signed [VB-1:0] sat_sum(input logic signed [VB:0] v);
        logic signed [VB-1:0] r;
        if (v[VB] != v[VB-1])
        begin
            r = v[VB] ? VMIN : VMAX;
        end
        else
        begin
            r = v[VB-1:0];
        end
        return r;
    endfunction

    function automatic logic [RB-1:0] clip_rate(input logic [RB-1:0] v);
        return (v > RB'(qltu_pkg::FIX_ONE)) ? RB'(qltu_pkg::FIX_ONE) : v;
    endfunction

    // configuration
    logic [RB-1:0]        learn_rate_reg, discount_reg, trace_decay_reg;
    logic signed [VB-1:0] impossible_reg;
    logic [6:0]           states_use_reg;
    logic [3:0]           actions_use_reg;

    // sequencer and item state
    qltu_pkg::state_t     state_reg, state_next;
    logic [1:0]           phase_reg;
    logic [SB-1:0]        pend_s_reg, obs_s_reg;
    logic [CB-1:0]        pend_a_reg, obs_a_reg;
    logic signed [VB-1:0] pend_r_reg, obs_r_reg;
    logic                 flag_reg;
    logic [AB-1:0]        clr_cnt_reg;
    logic [CB-1:0]        act_cnt_reg, a_cnt_reg, best_a_reg;
    logic [SB-1:0]        s_cnt_reg;
    logic signed [VB-1:0] best_v_reg, qidx_reg, sum_reg, delta_reg, step_reg, keep_reg;
    logic signed [VB-1:0] qk_reg, tk_reg;
    logic                 done_reg;

    // output register
    logic                 out_valid_reg, o_done_reg;
    logic [CB-1:0]        o_act_reg;
    logic signed [VB-1:0] o_val_reg, o_td_reg;

    // shared multiplier
    logic signed [VB:0]   mul_a_reg, mul_b_reg;
    logic [2*VB-1:0]      prod_reg;
    logic                 neg_reg;
    logic [VB-1:0]        mag_a, mag_b;
    logic [2*VB-1:0]      rnd;
    logic [2*VB-17:0]     rmag;
    logic signed [VB-1:0] mul_res;
    logic                 mul_load;
    logic signed [VB:0]   mul_a_next, mul_b_next;

    // tables
    logic          q_we, t_we;
    logic [AB-1:0] q_waddr, t_waddr, q_raddr, t_raddr;
    logic [VB-1:0] q_wdata, t_wdata, q_rdata, t_rdata;

    logic                 trace_mode, accept, upd_item, sweep_last, greedy;
    logic [6:0]           ns;
    logic [3:0]           na;
    logic [AB-1:0]        idx, k_addr;
    logic signed [VB-1:0] r_use;

    assign trace_mode = (trace_decay_reg != '0);
    assign ns = (states_use_reg == 7'd0) ? 7'd1 :
                (states_use_reg > 7'(qltu_pkg::MAX_STATES)) ? 7'(qltu_pkg::MAX_STATES)
                                                              : states_use_reg;
    assign na = (actions_use_reg == 4'd0) ? 4'd1 :
                (actions_use_reg > 4'(qltu_pkg::MAX_ACTIONS)) ? 4'(qltu_pkg::MAX_ACTIONS)
                                                                : actions_use_reg;
    assign idx    = {pend_s_reg, pend_a_reg};
    assign k_addr = {s_cnt_reg, a_cnt_reg};
    assign r_use  = (!trace_mode && flag_reg) ? impossible_reg : pend_r_reg;
    assign greedy = (obs_a_reg == best_a_reg);
    assign sweep_last = ({1'b0, a_cnt_reg} == na - 4'd1) && ({1'b0, s_cnt_reg} == ns - 7'd1);

    assign in_ready  = (state_reg == qltu_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign upd_item  = trace_mode ? (phase_reg == qltu_pkg::PHASE_STEADY)
                                  : (phase_reg != qltu_pkg::PHASE_START);

    assign out_valid     = out_valid_reg;
    assign update_done   = o_done_reg;
    assign greedy_action = o_act_reg;
    assign greedy_value  = o_val_reg;
    assign td_error      = o_td_reg;

    // multiplier: magnitudes, registered product, then round and saturate
    assign mag_a = VB'(mul_a_reg[VB] ? -mul_a_reg : mul_a_reg);
    assign mag_b = VB'(mul_b_reg[VB] ? -mul_b_reg : mul_b_reg);
    assign rnd   = prod_reg + (2*VB)'(32768);
    assign rmag  = rnd[2*VB-1:16];

    always_comb
    begin
        if (rmag[2*VB-17:VB-1] != '0)
        begin
            mul_res = neg_reg ? VMIN : VMAX;
        end
        else if (neg_reg)
        begin
            mul_res = -$signed({1'b0, rmag[VB-2:0]});
        end
        else
        begin
            mul_res = $signed({1'b0, rmag[VB-2:0]});
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mag_a * mag_b;
        neg_reg  <= mul_a_reg[VB] ^ mul_b_reg[VB];
        if (mul_load)
        begin
            mul_a_reg <= mul_a_next;
            mul_b_reg <= mul_b_next;
        end
    end

    qltu_ram #(.WIDTH(VB), .DEPTH(qltu_pkg::DEPTH)) u_q_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    qltu_ram #(.WIDTH(VB), .DEPTH(qltu_pkg::DEPTH)) u_t_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // sequencer datapath controls
    always_comb
    begin
        state_next = state_reg;
        q_we       = 1'b0;
        t_we       = 1'b0;
        q_waddr    = k_addr;
        t_waddr    = k_addr;
        q_wdata    = '0;
        t_wdata    = '0;
        q_raddr    = k_addr;
        t_raddr    = k_addr;
        mul_load   = 1'b0;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        case (state_reg)
            qltu_pkg::S_CLEAR:
            begin
                q_we    = 1'b1;
                t_we    = 1'b1;
                q_waddr = clr_cnt_reg;
                t_waddr = clr_cnt_reg;
                if (clr_cnt_reg == {AB{1'b1}})
                begin
                    state_next = qltu_pkg::S_IDLE;
                end
            end
            qltu_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = upd_item ? qltu_pkg::S_MAXRD : qltu_pkg::S_FINISH;
                end
            end
            qltu_pkg::S_MAXRD:
            begin
                q_raddr    = {obs_s_reg, act_cnt_reg};
                state_next = qltu_pkg::S_MAXCMP;
            end
            qltu_pkg::S_MAXCMP:
            begin
                state_next = ({1'b0, act_cnt_reg} == na - 4'd1) ? qltu_pkg::S_QRD
                                                                 : qltu_pkg::S_MAXRD;
            end
            qltu_pkg::S_QRD:
            begin
                q_raddr    = idx;
                state_next = qltu_pkg::S_GMUL;
            end
            qltu_pkg::S_GMUL:
            begin
                mul_load   = 1'b1;
                mul_a_next = $signed({16'd0, clip_rate(discount_reg)});
                mul_b_next = {best_v_reg[VB-1], best_v_reg};
                state_next = qltu_pkg::S_GWAIT;
            end
            qltu_pkg::S_GWAIT: state_next = qltu_pkg::S_SUM;
            qltu_pkg::S_SUM:   state_next = qltu_pkg::S_DELTA;
            qltu_pkg::S_DELTA: state_next = qltu_pkg::S_AMUL;
            qltu_pkg::S_AMUL:
            begin
                mul_load   = 1'b1;
                mul_a_next = $signed({16'd0, clip_rate(learn_rate_reg)});
                mul_b_next = {delta_reg[VB-1], delta_reg};
                t_raddr    = idx;
                state_next = qltu_pkg::S_AWAIT;
            end
            qltu_pkg::S_AWAIT:
            begin
                // trace of the pending pair gets one added before the sweep
                if (trace_mode)
                begin
                    t_we    = 1'b1;
                    t_waddr = idx;
                    t_wdata = sat_sum({t_rdata[VB-1], t_rdata} + (VB+1)'(qltu_pkg::FIX_ONE));
                    state_next = qltu_pkg::S_STEP;
                end
                else
                begin
                    state_next = qltu_pkg::S_UPD;
                end
            end
            qltu_pkg::S_UPD:
            begin
                q_we       = 1'b1;
                q_waddr    = idx;
                q_wdata    = sat_sum({qidx_reg[VB-1], qidx_reg} + {mul_res[VB-1], mul_res});
                state_next = qltu_pkg::S_FINISH;
            end
            qltu_pkg::S_STEP:
            begin
                mul_load   = 1'b1;
                mul_a_next = $signed({16'd0, clip_rate(discount_reg)});
                mul_b_next = $signed({16'd0, clip_rate(trace_decay_reg)});
                state_next = qltu_pkg::S_KWAIT;
            end
            qltu_pkg::S_KWAIT: state_next = qltu_pkg::S_KEEP;
            qltu_pkg::S_KEEP:  state_next = qltu_pkg::S_SWRD;
            qltu_pkg::S_SWRD:  state_next = qltu_pkg::S_SWMUL;
            qltu_pkg::S_SWMUL:
            begin
                mul_load   = 1'b1;
                mul_a_next = {step_reg[VB-1], step_reg};
                mul_b_next = {t_rdata[VB-1], t_rdata};
                state_next = qltu_pkg::S_SWW1;
            end
            qltu_pkg::S_SWW1: state_next = qltu_pkg::S_SWQ;
            qltu_pkg::S_SWQ:
            begin
                q_we    = 1'b1;
                q_wdata = sat_sum({qk_reg[VB-1], qk_reg} + {mul_res[VB-1], mul_res});
                if (greedy)
                begin
                    mul_load   = 1'b1;
                    mul_a_next = {keep_reg[VB-1], keep_reg};
                    mul_b_next = {tk_reg[VB-1], tk_reg};
                    state_next = qltu_pkg::S_SWW2;
                end
                else
                begin
                    // non-greedy action cuts every trace in the swept range
                    t_we       = 1'b1;
                    state_next = sweep_last ? qltu_pkg::S_FINISH : qltu_pkg::S_SWRD;
                end
            end
            qltu_pkg::S_SWW2: state_next = qltu_pkg::S_SWT;
            qltu_pkg::S_SWT:
            begin
                t_we       = 1'b1;
                t_wdata    = mul_res;
                state_next = sweep_last ? qltu_pkg::S_FINISH : qltu_pkg::S_SWRD;
            end
            qltu_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = qltu_pkg::S_IDLE;
                end
            end
            default: state_next = qltu_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= qltu_pkg::S_CLEAR;
            phase_reg       <= qltu_pkg::PHASE_START;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            pend_s_reg      <= '0;
            pend_a_reg      <= '0;
            pend_r_reg      <= '0;
            learn_rate_reg  <= RB'(6554);
            discount_reg    <= RB'(58982);
            trace_decay_reg <= '0;
            impossible_reg  <= '0;
            states_use_reg  <= 7'd64;
            actions_use_reg <= 4'd8;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == qltu_pkg::S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AB'(1);
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    qltu_pkg::REG_LEARN_RATE:  learn_rate_reg  <= cfg_data[RB-1:0];
                    qltu_pkg::REG_DISCOUNT:    discount_reg    <= cfg_data[RB-1:0];
                    qltu_pkg::REG_TRACE_DECAY: trace_decay_reg <= cfg_data[RB-1:0];
                    qltu_pkg::REG_IMPOSSIBLE:  impossible_reg  <= cfg_data;
                    qltu_pkg::REG_STATES_USE:  states_use_reg  <= cfg_data[6:0];
                    qltu_pkg::REG_ACTIONS_USE: actions_use_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (state_reg == qltu_pkg::S_FINISH && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                if (phase_reg != qltu_pkg::PHASE_STEADY)
                begin
                    phase_reg <= phase_reg + 2'd1;
                end
                if (!trace_mode)
                begin
                    pend_s_reg <= obs_s_reg;
                    pend_a_reg <= obs_a_reg;
                    pend_r_reg <= obs_r_reg;
                end
                else if (phase_reg == qltu_pkg::PHASE_START)
                begin
                    pend_s_reg <= obs_s_reg;
                end
                else if (phase_reg == qltu_pkg::PHASE_FIRST)
                begin
                    pend_a_reg <= obs_a_reg;
                    pend_r_reg <= flag_reg ? impossible_reg : obs_r_reg;
                end
                else
                begin
                    pend_s_reg <= obs_s_reg;
                    pend_a_reg <= obs_a_reg;
                    pend_r_reg <= flag_reg ? impossible_reg : obs_r_reg;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            obs_s_reg   <= observed_state;
            obs_a_reg   <= observed_action;
            obs_r_reg   <= observed_reward;
            flag_reg    <= impossible_flag;
            done_reg    <= upd_item;
            act_cnt_reg <= '0;
            best_a_reg  <= '0;
            best_v_reg  <= '0;
            delta_reg   <= '0;
        end
        if (state_reg == qltu_pkg::S_MAXCMP)
        begin
            if (act_cnt_reg == '0 || $signed(q_rdata) > best_v_reg)
            begin
                best_v_reg <= q_rdata;
                best_a_reg <= act_cnt_reg;
            end
            act_cnt_reg <= act_cnt_reg + CB'(1);
        end
        if (state_reg == qltu_pkg::S_GMUL)
        begin
            qidx_reg <= q_rdata;
        end
        if (state_reg == qltu_pkg::S_SUM)
        begin
            sum_reg <= sat_sum({r_use[VB-1], r_use} + {mul_res[VB-1], mul_res});
        end
        if (state_reg == qltu_pkg::S_DELTA)
        begin
            delta_reg <= sat_sum({sum_reg[VB-1], sum_reg} - {qidx_reg[VB-1], qidx_reg});
        end
        if (state_reg == qltu_pkg::S_STEP)
        begin
            step_reg <= mul_res;
        end
        if (state_reg == qltu_pkg::S_KEEP)
        begin
            keep_reg  <= mul_res;
            s_cnt_reg <= '0;
            a_cnt_reg <= '0;
        end
        if (state_reg == qltu_pkg::S_SWMUL)
        begin
            qk_reg <= q_rdata;
            tk_reg <= t_rdata;
        end
        if ((state_reg == qltu_pkg::S_SWQ && !greedy) || state_reg == qltu_pkg::S_SWT)
        begin
            if ({1'b0, a_cnt_reg} == na - 4'd1)
            begin
                a_cnt_reg <= '0;
                s_cnt_reg <= s_cnt_reg + SB'(1);
            end
            else
            begin
                a_cnt_reg <= a_cnt_reg + CB'(1);
            end
        end
        if (state_reg == qltu_pkg::S_FINISH && (!out_valid_reg || out_ready))
        begin
            o_done_reg <= done_reg;
            o_act_reg  <= best_a_reg;
            o_val_reg  <= best_v_reg;
            o_td_reg   <= delta_reg;
        end
    end

    a_no_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !o_done_reg |-> o_act_reg == '0 && o_val_reg == '0 && o_td_reg == '0)
        else $error("result without update carries nonzero fields");

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == qltu_pkg::S_SWQ |-> {1'b0, s_cnt_reg} < ns && {1'b0, a_cnt_reg} < na)
        else $error("sweep writes outside the sizes in use");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("episode phase out of range");

endmodule
`default_nettype wire

// ===== sim/q_learning_table_update_core_test.sv =====
// q_learning_table_update_core_test: self-checking bench for the q-learning table update core
// depends on qltu_pkg and q_learning_table_update_core; predicts every result in a local model
`timescale 1ns / 1ps
module q_learning_table_update_core_test;

    typedef struct {
        logic [5:0]  s;
        logic [2:0]  a;
        logic [31:0] r;
        logic        f;
    } obs_t;

    typedef struct {
        logic        d;
        logic [2:0]  ga;
        logic [31:0] gv;
        logic [31:0] td;
    } upd_t;

    typedef struct {
        logic [2:0]  idx;
        logic [31:0] data;
    } wr_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [5:0]  observed_state = 0;
    logic [2:0]  observed_action = 0;
    logic [31:0] observed_reward = 0;
    logic        impossible_flag = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic        update_done;
    logic [2:0]  greedy_action;
    logic [31:0] greedy_value;
    logic [31:0] td_error;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;

    q_learning_table_update_core uut (.*);

    always #2 clk = ~clk;

    obs_t obs_q[$];
    wr_t  wr_q[$];
    upd_t upd_q[$];
    int   send_idle = 0;
    int   recv_stall = 0;
    int   errors = 0;

    // model of the learner
    longint q_tbl[qltu_pkg::DEPTH];
    longint tr_tbl[qltu_pkg::DEPTH];
    int     p_state, p_action, nxt_state, phase;
    longint p_reward;
    int     m_lr = 6554, m_disc = 58982, m_lam = 0, m_ns = 64, m_na = 8;
    longint m_imp = 0;

    function automatic longint sat(longint v);
        longint lim;
        lim = longint'(1) << (qltu_pkg::VALUE_BITS - 1);
        if (v > lim - 1) return lim - 1;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint fix_mul(longint x, longint y);
        longint unsigned top, ma, mb, r;
        bit neg;
        top = longint'(1) << (qltu_pkg::VALUE_BITS - 1 + 16);
        ma = x < 0 ? -x : x;
        mb = y < 0 ? -y : y;
        neg = (x < 0) != (y < 0);
        if (ma != 0 && mb > top / ma) r = top >> 16;
        else r = (ma * mb + 32768) >> 16;
        return sat(neg ? -longint'(r) : longint'(r));
    endfunction

    function automatic longint clip_rate(int v);
        return v > qltu_pkg::FIX_ONE ? qltu_pkg::FIX_ONE : v;
    endfunction

    function automatic int best_of(int s, int na);
        int b;
        b = 0;
        for (int a = 1; a < na; a++)
            if (q_tbl[s * qltu_pkg::MAX_ACTIONS + a] > q_tbl[s * qltu_pkg::MAX_ACTIONS + b])
                b = a;
        return b;
    endfunction

    task automatic write_reg(wr_t w);
        case (w.idx)
            qltu_pkg::REG_LEARN_RATE:  m_lr = w.data[16:0];
            qltu_pkg::REG_DISCOUNT:    m_disc = w.data[16:0];
            qltu_pkg::REG_TRACE_DECAY: m_lam = w.data[16:0];
            qltu_pkg::REG_IMPOSSIBLE:  m_imp = longint'(signed'(w.data));
            qltu_pkg::REG_STATES_USE:  m_ns = w.data[6:0];
            qltu_pkg::REG_ACTIONS_USE: m_na = w.data[3:0];
            default: ;
        endcase
    endtask

    task automatic learn_step(obs_t o);
        int ns, na, idx, ga, k;
        longint alpha, gamma, lambda, r, gv, dl, stp, keep;
        bit greedy;
        upd_t u;
        ns = m_ns < 1 ? 1 : (m_ns > qltu_pkg::MAX_STATES ? qltu_pkg::MAX_STATES : m_ns);
        na = m_na < 1 ? 1 : (m_na > qltu_pkg::MAX_ACTIONS ? qltu_pkg::MAX_ACTIONS : m_na);
        alpha = clip_rate(m_lr);
        gamma = clip_rate(m_disc);
        lambda = clip_rate(m_lam);
        u = '{1'b0, 3'd0, 32'd0, 32'd0};
        if (m_lam == 0) begin
            if (phase != qltu_pkg::PHASE_START) begin
                r = o.f ? m_imp : p_reward;
                idx = p_state * qltu_pkg::MAX_ACTIONS + p_action;
                nxt_state = o.s;
                ga = best_of(o.s, na);
                gv = q_tbl[o.s * qltu_pkg::MAX_ACTIONS + ga];
                dl = sat(sat(r + fix_mul(gamma, gv)) - q_tbl[idx]);
                q_tbl[idx] = sat(q_tbl[idx] + fix_mul(alpha, dl));
                u = '{1'b1, ga[2:0], gv[31:0], dl[31:0]};
            end
            p_state = o.s;
            p_action = o.a;
            p_reward = longint'(signed'(o.r));
        end else begin
            r = o.f ? m_imp : longint'(signed'(o.r));
            if (phase == qltu_pkg::PHASE_START) begin
                p_state = o.s;
            end else if (phase == qltu_pkg::PHASE_FIRST) begin
                p_action = o.a;
                p_reward = r;
                nxt_state = o.s;
            end else begin
                idx = p_state * qltu_pkg::MAX_ACTIONS + p_action;
                nxt_state = o.s;
                ga = best_of(o.s, na);
                gv = q_tbl[o.s * qltu_pkg::MAX_ACTIONS + ga];
                dl = sat(sat(p_reward + fix_mul(gamma, gv)) - q_tbl[idx]);
                tr_tbl[idx] = sat(tr_tbl[idx] + qltu_pkg::FIX_ONE);
                stp = fix_mul(alpha, dl);
                keep = fix_mul(gamma, lambda);
                greedy = (o.a == ga);
                for (int s = 0; s < ns; s++)
                    for (int a = 0; a < na; a++) begin
                        k = s * qltu_pkg::MAX_ACTIONS + a;
                        q_tbl[k] = sat(q_tbl[k] + fix_mul(stp, tr_tbl[k]));
                        tr_tbl[k] = greedy ? fix_mul(keep, tr_tbl[k]) : 0;
                    end
                u = '{1'b1, ga[2:0], gv[31:0], dl[31:0]};
                p_state = o.s;
                p_action = o.a;
                p_reward = r;
            end
        end
        if (phase < qltu_pkg::PHASE_STEADY) phase++;
        upd_q.push_back(u);
    endtask

    // driver for both input channels
    always @(posedge clk or negedge rst_n) begin : drive
        obs_t o;
        wr_t  w;
        bit   in_hold, cfg_hold;
        if (!rst_n) begin
            in_valid <= 0;
            cfg_valid <= 0;
        end else begin
            in_hold = in_valid && !in_ready;
            cfg_hold = cfg_valid && !cfg_ready;
            if (in_valid && in_ready)
                learn_step('{observed_state, observed_action, observed_reward, impossible_flag});
            if (cfg_valid && cfg_ready)
                write_reg('{cfg_index, cfg_data});
            if (!in_hold) begin
                if (obs_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    o = obs_q.pop_front();
                    in_valid <= 1;
                    observed_state <= o.s;
                    observed_action <= o.a;
                    observed_reward <= o.r;
                    impossible_flag <= o.f;
                end else begin
                    in_valid <= 0;
                end
            end
            if (!cfg_hold) begin
                if (wr_q.size() > 0) begin
                    w = wr_q.pop_front();
                    cfg_valid <= 1;
                    cfg_index <= w.idx;
                    cfg_data <= w.data;
                end else begin
                    cfg_valid <= 0;
                end
            end
        end
    end

    // monitor of the result channel
    always @(posedge clk or negedge rst_n) begin : watch
        upd_t e;
        if (!rst_n) begin
            out_ready <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (upd_q.size() == 0) begin
                    $error("result item with nothing expected");
                    errors++;
                end else begin
                    e = upd_q.pop_front();
                    if (update_done !== e.d) begin
                        $error("update_done expected %0d got %0d", e.d, update_done);
                        errors++;
                    end
                    if (greedy_action !== e.ga) begin
                        $error("greedy_action expected %0d got %0d", e.ga, greedy_action);
                        errors++;
                    end
                    if (greedy_value !== e.gv) begin
                        $error("greedy_value expected %h got %h", e.gv, greedy_value);
                        errors++;
                    end
                    if (td_error !== e.td) begin
                        $error("td_error expected %h got %h", e.td, td_error);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic add_obs(int s, int a, logic [31:0] r, bit f);
        obs_q.push_back('{s[5:0], a[2:0], r, f});
    endtask

    function automatic logic [31:0] rand_reward();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return $urandom_range(0, 262144) - 131072;
        endcase
    endfunction

    function automatic logic [31:0] rand_rate();
        case ($urandom_range(5))
            0: return 0;
            1: return qltu_pkg::FIX_ONE;
            2: return 131071;
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    task automatic wait_idle();
        do @(negedge clk);
        while (wr_q.size() > 0 || obs_q.size() > 0 || in_valid || cfg_valid ||
               upd_q.size() > 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_regs(logic [31:0] lr, logic [31:0] dc, logic [31:0] lm,
                            logic [31:0] imp, logic [31:0] ns, logic [31:0] na);
        wait_idle();
        wr_q.push_back('{qltu_pkg::REG_LEARN_RATE, lr});
        wr_q.push_back('{qltu_pkg::REG_DISCOUNT, dc});
        wr_q.push_back('{qltu_pkg::REG_TRACE_DECAY, lm});
        wr_q.push_back('{qltu_pkg::REG_IMPOSSIBLE, imp});
        wr_q.push_back('{qltu_pkg::REG_STATES_USE, ns});
        wr_q.push_back('{qltu_pkg::REG_ACTIONS_USE, na});
        // unknown index, must be ignored
        wr_q.push_back('{3'd6 + 3'($urandom_range(1)), $urandom()});
        wait_idle();
    endtask

    initial begin : timeout
        #40ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stim
        int ns_eff, s;
        bit trace;
        repeat (5) @(posedge clk);
        rst_n <= 1;

        // one-step mode, full size, field extremes
        set_regs(6554, 58982, 0, 32'h80000000, 64, 8);
        add_obs(0, 0, 32'h7fffffff, 0);
        add_obs(63, 7, 32'h7fffffff, 0);
        add_obs(63, 7, 32'h80000000, 0);
        add_obs(0, 7, 32'h80000000, 1);
        add_obs(63, 0, 0, 1);
        add_obs(21, 5, 32'h00010000, 0);
        add_obs(42, 2, 32'hffff0000, 0);
        add_obs(21, 5, 32'h00008000, 1);
        add_obs(42, 3, 32'h12345678, 0);
        add_obs(0, 0, 32'h7fffffff, 0);
        wait_idle();
        // trace mode at rate extremes on a tiny table
        set_regs(131071, 65536, 65536, 32'h7fffffff, 2, 2);
        add_obs(0, 0, 32'h00010000, 0);
        add_obs(1, 1, 32'h7fffffff, 0);
        add_obs(0, 0, 32'h80000000, 1);
        add_obs(1, 1, 32'h7fffffff, 0);
        add_obs(0, 1, 32'h80000000, 0);
        add_obs(1, 0, 0, 1);
        add_obs(63, 7, 32'h7fffffff, 0);
        wait_idle();
        // trace mode, full sweep, sizes above range clamp
        set_regs(30000, 50000, 40000, 32'hfffe0000, 127, 15);
        for (int i = 0; i < 6; i++) add_obs($urandom_range(63), $urandom_range(7), rand_reward(), i == 4);
        wait_idle();
        // sizes of zero clamp to one
        set_regs(65536, 0, 65536, 32'h00020000, 0, 0);
        for (int i = 0; i < 4; i++) add_obs(i, i, rand_reward(), i == 3);

        for (int ph = 0; ph < 8; ph++) begin
            trace = ph % 3 != 0;
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 86; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 86; end
                default: begin send_idle = 20; recv_stall = 20; end
            endcase
            if (trace) begin
                ns_eff = $urandom_range(0, 6);
                set_regs(rand_rate(), rand_rate(), $urandom_range(2) == 0 ? 65536 : rand_rate() | 1,
                         $urandom(), ns_eff, $urandom_range(0, 15));
            end else begin
                ns_eff = $urandom_range(0, 127);
                set_regs(rand_rate(), rand_rate(), 0, $urandom(), ns_eff, $urandom_range(0, 15));
            end
            if (ns_eff < 1) ns_eff = 1;
            if (ns_eff > qltu_pkg::MAX_STATES) ns_eff = qltu_pkg::MAX_STATES;
            for (int i = 0; i < 140; i++) begin
                // keep most states inside the swept range
                s = $urandom_range(9) < 8 ? $urandom_range(ns_eff - 1) : $urandom_range(63);
                add_obs(s, $urandom_range(7), rand_reward(), $urandom_range(9) == 0);
            end
        end

        wait_idle();
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/qltu_pkg.sv
hw/rtl/qltu_ram.sv
hw/rtl/q_learning_table_update_core.sv
sim/q_learning_table_update_core_test.sv
